@@ rtl/assert_macros.svh @@
// Assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
`define LFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define LFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/lfd_pkg.sv @@
// Package with constants, result type and CRC helper for the deframer.
`default_nettype none
package lfd_pkg;

  localparam int PAYLOAD_BYTES = 4;
  localparam int BODY_LEN      = PAYLOAD_BYTES + 4;
  localparam int IDX_W         = $clog2(BODY_LEN);
  localparam int PAY_SHOWN     = (PAYLOAD_BYTES < 4) ? PAYLOAD_BYTES : 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_GOOD = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_seq;
    logic [31:0] frame_payload;
    logic [31:0] good_count;
    logic [31:0] bad_count;
  } result_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lfd_out_skid.sv @@
// Two-entry output stage: result register plus a skid register.
`default_nettype none
module lfd_out_skid (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire lfd_pkg::result_t in_word,
  output logic                  in_stall,
  output logic                  out_valid,
  output lfd_pkg::result_t      out_word,
  input  wire logic             out_stall
);
  import lfd_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    push;
  logic    take;

  assign push = in_valid && !skid_valid_r;
  assign take = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || take) begin
      // The skid word always goes first; no push happens while it is held.
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        main_nxt       = in_word;
        main_valid_nxt = 1'b1;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt       = in_word;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_word  = main_r;

endmodule
`default_nettype wire

@@ rtl/link_frame_deframer_crc16_unit.sv @@
// Each accepted byte places a result word in the output stage's result or skid register.
// Throughput: one byte per cycle while in_stall is low; the CRC byte update is one shallow stage.
// A two-entry output stage absorbs output stall; input stalls once its skid register is full.
// Reset (synchronous, rst_n low): hunt restarts, CRC to 0xFFFF, counters to zero,
// sync bytes to 0xAA and 0x55; body byte storage is not cleared.
`include "assert_macros.svh"
`default_nettype none
module link_frame_deframer_crc16_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_frame_status,
  output logic [7:0]                         out_frame_type,
  output logic [7:0]                         out_frame_seq,
  output logic [31:0]                        out_frame_payload,
  output logic [31:0]                        out_good_count,
  output logic [31:0]                        out_bad_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import lfd_pkg::*;

  localparam logic [1:0] PH_SYNC1 = 2'd0;
  localparam logic [1:0] PH_SYNC2 = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  logic [7:0]       sync_first_r;
  logic [7:0]       sync_second_r;
  logic [1:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [31:0]      good_r, good_nxt;
  logic [31:0]      bad_r, bad_nxt;
  logic [7:0]       body_r [BODY_LEN];

  logic             accept;
  logic [IDX_W-1:0] wr_idx;
  logic             body_wr;
  logic             last_byte;
  logic [15:0]      want_crc;
  result_t          res;
  result_t          out_word;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // A body index past the end cannot arise, but is held at the last slot.
  assign wr_idx = ({1'b0, idx_r} >= (IDX_W+1)'(BODY_LEN)) ? IDX_W'(BODY_LEN - 1) : idx_r;
  assign last_byte = (wr_idx == IDX_W'(BODY_LEN - 1));
  assign body_wr   = accept && (phase_r == PH_BODY);
  assign want_crc  = {in_rx_byte, body_r[BODY_LEN-2]};

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    res       = '0;
    unique case (phase_r)
      PH_SYNC2: begin
        if (in_rx_byte == sync_second_r) begin
          phase_nxt = PH_BODY;
          idx_nxt   = '0;
          crc_nxt   = CRC_INIT;
        end else if (in_rx_byte != sync_first_r) begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_BODY: begin
        if ({1'b0, wr_idx} < (IDX_W+1)'(BODY_LEN - 2)) begin
          crc_nxt = crc16_byte(crc_r, in_rx_byte);
        end
        idx_nxt = wr_idx + IDX_W'(1);
        if (last_byte) begin
          phase_nxt = PH_SYNC1;
          idx_nxt   = '0;
          crc_nxt   = CRC_INIT;
          if (crc_r != want_crc) begin
            bad_nxt          = bad_r + 32'd1;
            res.frame_status = ST_BAD;
          end else begin
            good_nxt         = good_r + 32'd1;
            res.frame_status = ST_GOOD;
            res.frame_type   = body_r[0];
            res.frame_seq    = body_r[1];
            for (int k = 0; k < PAY_SHOWN; k++) begin
              res.frame_payload[8*k +: 8] = body_r[2+k];
            end
          end
        end
      end
      default: begin
        phase_nxt = (in_rx_byte == sync_first_r) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
    res.good_count = good_nxt;
    res.bad_count  = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      phase_r       <= PH_SYNC1;
      idx_r         <= '0;
      crc_r         <= CRC_INIT;
      good_r        <= '0;
      bad_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SYNC_FIRST) begin
          sync_first_r <= cfg_data;
        end else if (cfg_index == CFG_SYNC_SECOND) begin
          sync_second_r <= cfg_data;
        end
      end
      if (accept) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        crc_r   <= crc_nxt;
        good_r  <= good_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (body_wr) begin
      body_r[wr_idx] <= in_rx_byte;
    end
  end

  lfd_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_word   (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

  assign out_frame_status  = out_word.frame_status;
  assign out_frame_type    = out_word.frame_type;
  assign out_frame_seq     = out_word.frame_seq;
  assign out_frame_payload = out_word.frame_payload;
  assign out_good_count    = out_word.good_count;
  assign out_bad_count     = out_word.bad_count;

  // The skid register only fills behind a held result word.
  `LFD_ASSERT_IMPL(a_stall_needs_out, clk, rst_n, in_stall, out_valid)
  // Counters move only on a byte taken inside a body.
  `LFD_ASSERT_NEXT(a_cnt_body_only, clk, rst_n, accept && (phase_r != PH_BODY),
                   (good_r == $past(good_r)) && (bad_r == $past(bad_r)))
  // The last body byte always sends the hunt back to the start.
  `LFD_ASSERT_NEXT(a_frame_end, clk, rst_n, accept && (phase_r == PH_BODY) && last_byte,
                   (phase_r == PH_SYNC1) && (idx_r == '0) && (crc_r == CRC_INIT))

endmodule
`default_nettype wire
